### src/kdpwm_pkg.sv
// Shared types, constants and register map for the key-driven PWM duty control block.
package kdpwm_pkg;

   // key codes, also used as event codes
   typedef logic [1:0] key_code_type;
   localparam key_code_type KEY_NONE   = 2'd0;
   localparam key_code_type KEY_INC    = 2'd1;
   localparam key_code_type KEY_DEC    = 2'd2;
   localparam key_code_type KEY_TOGGLE = 2'd3;

   localparam int DUTY_W   = 7;
   localparam int PERIOD_W = 16;
   localparam int PROD_W   = DUTY_W + PERIOD_W;
   localparam int DIV_STEPS = PERIOD_W;
   localparam int CNT_W    = $clog2(DIV_STEPS);

   localparam logic [DUTY_W-1:0] DUTY_STEP = 7'd5;

   // register map, index = paddr[3:2]
   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_DUTY_MAX   = 2'd0;
   localparam reg_index_type REG_DUTY_MIN   = 2'd1;
   localparam reg_index_type REG_TIMER_TOP  = 2'd2;

   localparam logic [DUTY_W-1:0]   DUTY_MAX_RESET   = 7'd100;
   localparam logic [DUTY_W-1:0]   DUTY_MIN_RESET   = 7'd0;
   localparam logic [PERIOD_W-1:0] TIMER_TOP_RESET  = 16'd50;

   // key stage status handed to the sequencer
   typedef struct packed {
      key_code_type      key_event;
      logic [DUTY_W-1:0] duty;
      logic              run;
   } key_status_type;

endpackage

### src/kdpwm_keys.sv
// Key debounce, press detection and duty / run state update.
module kdpwm_keys (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             sample_en,
   input  logic                             key1_pin,
   input  logic                             key2_pin,
   input  logic                             key3_pin,
   input  logic [kdpwm_pkg::DUTY_W-1:0]     duty_max,
   input  logic [kdpwm_pkg::DUTY_W-1:0]     duty_min,
   output kdpwm_pkg::key_status_type        status
);

   kdpwm_pkg::key_code_type code;
   kdpwm_pkg::key_code_type prev_ff, prev_in;
   kdpwm_pkg::key_code_type reported_ff, reported_in;
   kdpwm_pkg::key_code_type event_ff, event_in;
   logic [kdpwm_pkg::DUTY_W-1:0] duty_ff, duty_in;
   logic                         run_ff, run_in;
   logic [kdpwm_pkg::DUTY_W:0]   duty_up;
   logic [kdpwm_pkg::DUTY_W:0]   min_plus;

   // active-low keys, key1 wins
   always_comb begin
      if (!key1_pin)      code = kdpwm_pkg::KEY_INC;
      else if (!key2_pin) code = kdpwm_pkg::KEY_DEC;
      else if (!key3_pin) code = kdpwm_pkg::KEY_TOGGLE;
      else                code = kdpwm_pkg::KEY_NONE;
   end

   assign duty_up  = {1'b0, duty_ff} + {1'b0, kdpwm_pkg::DUTY_STEP};
   assign min_plus = {1'b0, duty_min} + {1'b0, kdpwm_pkg::DUTY_STEP};

   always_comb begin
      prev_in     = prev_ff;
      reported_in = reported_ff;
      event_in    = event_ff;
      duty_in     = duty_ff;
      run_in      = run_ff;
      if (sample_en) begin
         prev_in  = code;
         event_in = kdpwm_pkg::KEY_NONE;
         if (code == prev_ff) begin
            if (code == kdpwm_pkg::KEY_NONE) begin
               reported_in = kdpwm_pkg::KEY_NONE;
            end else if (code != reported_ff) begin
               reported_in = code;
               event_in    = code;
            end
         end
         case (event_in)
            kdpwm_pkg::KEY_INC: begin
               if (duty_up > {1'b0, duty_max}) duty_in = duty_max;
               else                            duty_in = duty_up[kdpwm_pkg::DUTY_W-1:0];
            end
            kdpwm_pkg::KEY_DEC: begin
               if ({1'b0, duty_ff} < min_plus) duty_in = duty_min;
               else                            duty_in = duty_ff - kdpwm_pkg::DUTY_STEP;
            end
            kdpwm_pkg::KEY_TOGGLE: run_in = ~run_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= kdpwm_pkg::KEY_NONE;
         reported_ff <= kdpwm_pkg::KEY_NONE;
         event_ff    <= kdpwm_pkg::KEY_NONE;
         duty_ff     <= '0;
         run_ff      <= 1'b0;
      end else begin
         prev_ff     <= prev_in;
         reported_ff <= reported_in;
         event_ff    <= event_in;
         duty_ff     <= duty_in;
         run_ff      <= run_in;
      end
   end

   assign status.key_event = event_ff;
   assign status.duty      = duty_ff;
   assign status.run       = run_ff;

endmodule

### src/kdpwm_div.sv
// Shared restoring divider, one quotient bit per cycle.
module kdpwm_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [kdpwm_pkg::PROD_W-1:0]       dividend,
   input  logic [kdpwm_pkg::DUTY_W-1:0]       divisor,
   output logic [kdpwm_pkg::PERIOD_W-1:0]     quotient,
   output logic                               done
);

   // dividend high part is below the divisor, so only PERIOD_W quotient bits exist
   logic [kdpwm_pkg::DUTY_W-1:0]   rem_ff, rem_in;
   logic [kdpwm_pkg::PERIOD_W-1:0] quo_ff, quo_in;
   logic [kdpwm_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [kdpwm_pkg::DUTY_W:0]     trial;
   logic [kdpwm_pkg::DUTY_W:0]     diff;

   assign trial = {rem_ff, quo_ff[kdpwm_pkg::PERIOD_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[kdpwm_pkg::PROD_W-1:kdpwm_pkg::PERIOD_W];
         quo_in  = dividend[kdpwm_pkg::PERIOD_W-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[kdpwm_pkg::DUTY_W-1:0];
            quo_in = {quo_ff[kdpwm_pkg::PERIOD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[kdpwm_pkg::DUTY_W-1:0];
            quo_in = {quo_ff[kdpwm_pkg::PERIOD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + kdpwm_pkg::CNT_W'(1);
         if (cnt_ff == kdpwm_pkg::CNT_W'(kdpwm_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

### src/key_driven_pwm_duty_control.sv
// Top level of the key-driven PWM duty control block.
// One key sample per req transaction yields exactly one rsp transaction carrying the
// debounced press event, the duty setting, the run state and the PWM compare value
// duty * timer_top / duty_max, duty capped at duty_max (0 when stopped or duty_max
// is 0). Otherwise an item goes from acceptance to the output register through
// key update at acceptance, then the multiply state, divider load, 16 restoring
// divider steps, quotient capture and result load; in those two cases, through the
// multiply state and result load. req_tready is high only while the sequencer is
// idle, so the next sample is taken in the cycle after the result load at the
// earliest. The result register holds a finished result while the next sample is
// taken, so the output side may stall without blocking input until the next result
// is ready. Registers sit on a small APB-style port at byte addresses 0 (duty_max),
// 4 (duty_min) and 8 (timer_top); write them only while no transaction is in flight.
module key_driven_pwm_duty_control (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] key1_pin, [1] key2_pin, [2] key3_pin, rest zero
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] key_event, [8:2] duty_percent, [9] run_state,
                                    // [25:10] compare_value, rest zero
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MUL   = 5'b00010,
      S_START = 5'b00100,
      S_DIV   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // config registers
   logic [kdpwm_pkg::DUTY_W-1:0]   duty_max_ff, duty_max_in;
   logic [kdpwm_pkg::DUTY_W-1:0]   duty_min_ff, duty_min_in;
   logic [kdpwm_pkg::PERIOD_W-1:0] timer_top_ff, timer_top_in;
   logic                           csr_write;
   kdpwm_pkg::reg_index_type       csr_index;

   // datapath
   logic [kdpwm_pkg::PROD_W-1:0]   product_ff, product_in;
   logic [kdpwm_pkg::PERIOD_W-1:0] compare_ff, compare_in;
   logic [kdpwm_pkg::DUTY_W-1:0]   duty_clip;
   logic                           req_accept;
   logic                           rsp_free;
   logic                           div_start;
   logic                           div_done;
   logic [kdpwm_pkg::PERIOD_W-1:0] div_quotient;
   kdpwm_pkg::key_status_type      key_status;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign div_start  = (state_ff == S_START);

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      duty_max_in  = duty_max_ff;
      duty_min_in  = duty_min_ff;
      timer_top_in = timer_top_ff;
      if (csr_write) begin
         case (csr_index)
            kdpwm_pkg::REG_DUTY_MAX:  duty_max_in  = csr_pwdata[kdpwm_pkg::DUTY_W-1:0];
            kdpwm_pkg::REG_DUTY_MIN:  duty_min_in  = csr_pwdata[kdpwm_pkg::DUTY_W-1:0];
            kdpwm_pkg::REG_TIMER_TOP: timer_top_in = csr_pwdata[kdpwm_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         kdpwm_pkg::REG_DUTY_MAX:  csr_prdata = {25'd0, duty_max_ff};
         kdpwm_pkg::REG_DUTY_MIN:  csr_prdata = {25'd0, duty_min_ff};
         kdpwm_pkg::REG_TIMER_TOP: csr_prdata = {16'd0, timer_top_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------- key stage ----------------
   kdpwm_keys u_keys (
      .clock     (clock),
      .reset     (reset),
      .sample_en (req_accept),
      .key1_pin  (req_tdata[0]),
      .key2_pin  (req_tdata[1]),
      .key3_pin  (req_tdata[2]),
      .duty_max  (duty_max_ff),
      .duty_min  (duty_min_ff),
      .status    (key_status)
   );

   // ---------------- shared divider ----------------
   kdpwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_ff),
      .divisor  (duty_max_ff),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // duty above max is scaled as max
   assign duty_clip = (key_status.duty > duty_max_ff) ? duty_max_ff : key_status.duty;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      product_in   = product_ff;
      compare_in   = compare_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_MUL;
         end
         S_MUL: begin
            // key state already updated; stopped or zero max skips the divide
            product_in = {{kdpwm_pkg::PERIOD_W{1'b0}}, duty_clip} *
                         {{kdpwm_pkg::DUTY_W{1'b0}}, timer_top_ff};
            if (!key_status.run || duty_max_ff == '0) begin
               compare_in = '0;
               state_in   = S_DONE;
            end else begin
               state_in = S_START;
            end
         end
         S_START: state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               compare_in = div_quotient;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, compare_ff, key_status.run, key_status.duty,
                               key_status.key_event};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         duty_max_ff  <= kdpwm_pkg::DUTY_MAX_RESET;
         duty_min_ff  <= kdpwm_pkg::DUTY_MIN_RESET;
         timer_top_ff <= kdpwm_pkg::TIMER_TOP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         duty_max_ff  <= duty_max_in;
         duty_min_ff  <= duty_min_in;
         timer_top_ff <= timer_top_in;
      end
      product_ff  <= product_in;
      compare_ff  <= compare_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !key_status.run) |-> (compare_ff == '0))
      else $error("compare value nonzero while stopped");

   a_cmp_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (compare_ff <= timer_top_ff))
      else $error("compare value above period");

   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_MUL))
      else $error("accepted sample did not start the sequencer");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

endmodule

### tb/sv/duty_control_checker.sv
// Checker for the key-driven PWM duty control: predicts each result and compares it.
module duty_control_checker
   import kdpwm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PERIOD_W-1:0] compare_value;
      logic                run_state;
      logic [DUTY_W-1:0]   duty_percent;
      key_code_type        key_press;
   } duty_result_type;

   // register copies
   logic [DUTY_W-1:0]   max_limit;
   logic [DUTY_W-1:0]   min_limit;
   logic [PERIOD_W-1:0] period;

   // key and duty state
   key_code_type        last_code;
   key_code_type        reported;
   logic [DUTY_W-1:0]   duty;
   logic                running;

   duty_result_type     expected_results [$];

   // debounce one sample, update duty and mode, return the resulting status
   function automatic duty_result_type apply_key_sample(input logic [2:0] pins);
      key_code_type        code;
      key_code_type        press;
      logic [DUTY_W:0]     raised;
      logic [DUTY_W-1:0]   capped;
      logic [PROD_W-1:0]   product;
      duty_result_type     r;

      if (!pins[0])      code = KEY_INC;
      else if (!pins[1]) code = KEY_DEC;
      else if (!pins[2]) code = KEY_TOGGLE;
      else               code = KEY_NONE;

      press = KEY_NONE;
      if (code == last_code) begin
         if (code == KEY_NONE) begin
            reported = KEY_NONE;
         end else if (code != reported) begin
            reported = code;
            press    = code;
         end
      end
      last_code = code;

      case (press)
         KEY_INC: begin
            raised = {1'b0, duty} + {1'b0, DUTY_STEP};
            duty   = (raised > {1'b0, max_limit}) ? max_limit : raised[DUTY_W-1:0];
         end
         KEY_DEC: begin
            // duty - 5 below the floor clamps to the floor
            if ({1'b0, duty} < {1'b0, min_limit} + {1'b0, DUTY_STEP}) duty = min_limit;
            else duty = duty - DUTY_STEP;
         end
         KEY_TOGGLE: begin
            running = ~running;
         end
         default: ;
      endcase

      r.key_press    = press;
      r.duty_percent = duty;
      r.run_state    = running;
      if (!running || max_limit == '0) begin
         r.compare_value = '0;
      end else begin
         capped  = (duty > max_limit) ? max_limit : duty;
         product = {{PERIOD_W{1'b0}}, capped} * {{DUTY_W{1'b0}}, period};
         r.compare_value = PERIOD_W'(product / {{(PROD_W-DUTY_W){1'b0}}, max_limit});
      end
      return r;
   endfunction

   always @(posedge clock) begin
      duty_result_type got;
      duty_result_type want;

      if (reset) begin
         max_limit      = DUTY_MAX_RESET;
         min_limit      = DUTY_MIN_RESET;
         period         = TIMER_TOP_RESET;
         last_code      = KEY_NONE;
         reported       = KEY_NONE;
         duty           = '0;
         running        = 1'b0;
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_DUTY_MAX:  max_limit = csr_pwdata[DUTY_W-1:0];
               REG_DUTY_MIN:  min_limit = csr_pwdata[DUTY_W-1:0];
               REG_TIMER_TOP: period    = csr_pwdata[PERIOD_W-1:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[25:0];
            if (expected_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result transaction %h", $realtime, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.key_press     != want.key_press    ||
                   got.duty_percent  != want.duty_percent ||
                   got.run_state     != want.run_state    ||
                   got.compare_value != want.compare_value ||
                   rsp_tdata[31:26]  != '0) begin
                  if (mismatch_count < 10)
                     $display({"%0t: result mismatch: key %0d/%0d duty %0d/%0d ",
                               "run %0d/%0d cmp %0d/%0d (exp/act) tdata %h"},
                        $realtime, want.key_press, got.key_press, want.duty_percent,
                        got.duty_percent, want.run_state, got.run_state,
                        want.compare_value, got.compare_value, rsp_tdata);
                  mismatch_count++;
               end
            end
         end

         if (req_tvalid && req_tready)
            expected_results.push_back(apply_key_sample(req_tdata[2:0]));
      end
      outstanding = expected_results.size();
   end

endmodule

### tb/sv/testbench.sv
// Top of the key-driven PWM duty control testbench: clock, reset, stimulus and verdict.
module testbench;

   import kdpwm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // key pin patterns {key3, key2, key1}, active low
   localparam logic [2:0] PINS_IDLE = 3'b111;
   localparam logic [2:0] PINS_KEY1 = 3'b110;
   localparam logic [2:0] PINS_KEY2 = 3'b101;
   localparam logic [2:0] PINS_KEY3 = 3'b011;

   localparam int ITEMS_PER_PHASE = 55;
   localparam int LONG_HOLD       = 300;   // receiver hold-off, cycles
   localparam int STALL_LIMIT     = 2000;  // cycles without any transaction
   localparam int DRAIN_CYCLES    = 40;    // margin for late extra results after the drain

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [0] key1_pin, [1] key2_pin, [2] key3_pin, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;     // [1:0] key_event, [8:2] duty_percent, [9] run_state,
                               // [25:10] compare_value, rest zero
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatch_count;
   int          outstanding;

   // sender pacing: every 32 samples decide whether the next stretch runs gap-free
   int          samples_sent = 0;
   logic        sender_calm  = 1'b0;

   int          idle_cycles  = 0;

   key_driven_pwm_duty_control i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   duty_control_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog: any req, rsp or register transaction counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, outstanding);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side. Draws a random stall per transaction, with gap-free stretches,
   // and twice, after 110 and 300 results, holds off so the result register fills and
   // the block has to stall its input while samples keep coming.
   initial begin
      int   taken;
      int   stall;
      logic calm;

      taken      = 0;
      calm       = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken % 40 == 0) calm = ($urandom_range(0, 2) == 0);
         if (taken == 110 || taken == 300) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            stall = calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
               rsp_tready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   // Offer one key sample; entered and left at a falling edge. With no gap the
   // valid simply stays high into the next transaction.
   task automatic send_sample(input logic [2:0] pins);
      int gap;

      if (samples_sent % 32 == 0) sender_calm = ($urandom_range(0, 2) == 0);
      gap = sender_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {5'b0, pins};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
      @(negedge clock);
   endtask

   // Stop offering and wait until every predicted result has been taken.
   task automatic drain_results();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands at the rising edge in the access cycle.
   task automatic write_reg(input reg_index_type index, input logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_limits(input int max_pct, input int min_pct, input int top);
      drain_results();
      write_reg(REG_DUTY_MAX, max_pct);
      write_reg(REG_DUTY_MIN, min_pct);
      write_reg(REG_TIMER_TOP, top);
   endtask

   // Mostly clean presses: a key held for 2..4 samples and then released, which
   // is what gets through the debounce. The rest is single random samples.
   task automatic key_traffic(input int count);
      int          sent;
      int          hold;
      int          gap;
      logic [2:0]  pins;

      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 4))
               0, 1:    pins = PINS_KEY1;
               2:       pins = PINS_KEY2;
               3:       pins = PINS_KEY3;
               default: pins = 3'($urandom_range(0, 7));
            endcase
            hold = $urandom_range(2, 4);
            gap  = $urandom_range(1, 2);
            repeat (hold) send_sample(pins);
            repeat (gap) send_sample(PINS_IDLE);
            sent += hold + gap;
         end else begin
            send_sample(3'($urandom_range(0, 7)));
            sent++;
         end
      end
   endtask

   initial begin
      logic [2:0] directed_pins [$];

      // directed sequence under the reset register values
      directed_pins = '{
         PINS_IDLE,                  // stable release right after reset
         PINS_KEY2, PINS_KEY2,       // decrease at zero, clamps at the floor
         PINS_KEY3, PINS_KEY3,       // unstable, then toggle to run
         PINS_KEY1, PINS_KEY1,       // increase
         PINS_KEY1,                  // held key, no event
         3'b000,                     // all keys: key1 wins, still held
         PINS_IDLE, PINS_IDLE,       // unstable, then stable release
         PINS_KEY1, PINS_KEY1,       // same key counts again after release
         3'b100,                     // key1 + key2 still code key1
         PINS_KEY2,                  // unstable change of code
         3'b001,                     // key2 + key3: new decrease press
         3'b010,                     // key1 + key3: unstable
         PINS_IDLE, PINS_IDLE,
         PINS_KEY3, PINS_KEY3,       // back to stopped
         PINS_KEY1, PINS_KEY1,       // duty moves while stopped, compare stays 0
         PINS_IDLE
      };

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_pins[i]) send_sample(directed_pins[i]);

      // random traffic over a series of limit settings, extremes first
      set_limits(100, 0, 65535);       // full-width period
      key_traffic(ITEMS_PER_PHASE);
      set_limits(1, 0, 1);             // smallest limits, duty now above max
      key_traffic(ITEMS_PER_PHASE);
      set_limits(20, 60, 1000);        // max below min
      key_traffic(ITEMS_PER_PHASE);
      set_limits(0, 0, 777);           // zero max: compare forced to 0
      key_traffic(ITEMS_PER_PHASE);
      set_limits(100, 100, 65535);     // floor at the top
      key_traffic(ITEMS_PER_PHASE);
      set_limits(100, 0, 50);          // back to reset values
      key_traffic(ITEMS_PER_PHASE);
      repeat (3) begin
         int max_pct;
         max_pct = $urandom_range(1, 100);
         set_limits(max_pct, $urandom_range(0, max_pct), $urandom_range(1, 65535));
         key_traffic(ITEMS_PER_PHASE);
      end

      // let the pipeline drain and give late extra results a chance to show
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
